@@ rtl/bpa_pkg.sv @@
`timescale 1ns / 1ps

package bpa_pkg;

    localparam int NUM_PAGES     = 32768;
    localparam int PAGE_BYTES    = 4096;
    localparam int MAP_WORD_BITS = 32;

    localparam int MAP_WORDS   = (NUM_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int WORD_AW     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_W       = $clog2(MAP_WORD_BITS);
    localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
    localparam int PAGE_IDX_W  = WORD_AW + BIT_W;
    localparam int ADDR_W      = 32;
    localparam int IN_PAGE_W   = ADDR_W - PAGE_SHIFT;
    localparam int PAGE_ADDR_W = 27;
    localparam int LAST_BITS   = NUM_PAGES - (MAP_WORDS - 1) * MAP_WORD_BITS;

    localparam logic [WORD_AW-1:0]       LAST_WORD = WORD_AW'(MAP_WORDS - 1);
    localparam logic [IN_PAGE_W-1:0]     PAGE_LIMIT = IN_PAGE_W'(NUM_PAGES);
    localparam logic [MAP_WORD_BITS-1:0] TAIL_MASK =
        {MAP_WORD_BITS{1'b1}} << LAST_BITS;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FREE
    } t_state;

    typedef struct packed {
        logic                     found;
        logic [BIT_W-1:0]         bit_idx;
        logic [MAP_WORD_BITS-1:0] onehot;
    } t_ffz;

endpackage

@@ rtl/bpa_ram.sv @@
`timescale 1ns / 1ps

module bpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

@@ rtl/bpa_ffz.sv @@
`timescale 1ns / 1ps

module bpa_ffz
    import bpa_pkg::*;
(
    input  logic [MAP_WORD_BITS-1:0] i_word,
    output t_ffz                     o_ffz
);

    logic [MAP_WORD_BITS-1:0] inv;
    logic [MAP_WORD_BITS-1:0] low;
    logic [BIT_W-1:0]         enc;

    assign inv = ~i_word;
    assign low = inv & (~inv + MAP_WORD_BITS'(1));

    always_comb begin
        enc = '0;
        for (int j = 0; j < BIT_W; j++) begin
            for (int k = 0; k < MAP_WORD_BITS; k++) begin
                if (((k >> j) & 1) == 1) begin
                    enc[j] = enc[j] | low[k];
                end
            end
        end
    end

    assign o_ffz.found   = |inv;
    assign o_ffz.bit_idx = enc;
    assign o_ffz.onehot  = low;

endmodule

@@ rtl/bitmap_page_allocator.sv @@
`timescale 1ns / 1ps
// Allocate: map words are scanned from word 0 up to the first word with a free page or the
// last word; one map word per cycle through the map RAM read port, then the result strobe.
// Free: in range through S_FREE, out of range refused from S_IDLE; the next item is accepted
// on the strobe cycle. Reset: busy while every map RAM word is swept to zero.
// Results are one-cycle strobes; the receiver cannot stall.

module bitmap_page_allocator
    import bpa_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   i_kind,
    input  logic [ADDR_W-1:0]      i_free_address,
    output logic                   o_valid,
    output logic [PAGE_ADDR_W-1:0] o_page_address,
    output logic                   o_success
);

    t_state                   r_state, n_state;
    logic [WORD_AW-1:0]       r_ptr, n_ptr;
    logic [BIT_W-1:0]         r_bit, n_bit;
    logic                     r_valid, n_valid;
    logic [PAGE_ADDR_W-1:0]   r_page_address, n_page_address;
    logic                     r_success, n_success;

    logic                     ram_we;
    logic [WORD_AW-1:0]       ram_waddr;
    logic [MAP_WORD_BITS-1:0] ram_wdata;
    logic [WORD_AW-1:0]       ram_raddr;
    logic [MAP_WORD_BITS-1:0] ram_rdata;

    logic [MAP_WORD_BITS-1:0] scan_word;
    t_ffz                     ffz;

    logic [IN_PAGE_W-1:0]     in_page;
    logic                     in_range;
    logic [WORD_AW-1:0]       free_word;
    logic [BIT_W-1:0]         free_bit;
    logic                     at_last;
    logic [PAGE_IDX_W+PAGE_SHIFT-1:0] grant_full;

    bpa_ram #(
        .WIDTH (MAP_WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign at_last   = (r_ptr == LAST_WORD);
    assign scan_word = at_last ? (ram_rdata | TAIL_MASK) : ram_rdata;

    bpa_ffz u_ffz (
        .i_word (scan_word),
        .o_ffz  (ffz)
    );

    assign in_page    = i_free_address[ADDR_W-1:PAGE_SHIFT];
    assign in_range   = (in_page < PAGE_LIMIT);
    assign free_word  = in_page[PAGE_IDX_W-1:BIT_W];
    assign free_bit   = in_page[BIT_W-1:0];
    assign grant_full = {r_ptr, ffz.bit_idx, PAGE_SHIFT'(0)};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (at_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    if (i_kind == KIND_ALLOC) begin
                        n_state = S_SCAN;
                    end else if (in_range) begin
                        n_state = S_FREE;
                    end
                end
            end
            S_SCAN: begin
                if (ffz.found || at_last) begin
                    n_state = S_IDLE;
                end
            end
            S_FREE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        ram_we         = 1'b0;
        ram_waddr      = r_ptr;
        ram_wdata      = '0;
        ram_raddr      = '0;
        n_ptr          = r_ptr;
        n_bit          = r_bit;
        n_valid        = 1'b0;
        n_page_address = '0;
        n_success      = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
                n_ptr  = at_last ? '0 : r_ptr + WORD_AW'(1);
            end
            S_IDLE: begin
                ram_raddr = (i_kind == KIND_FREE) ? free_word : '0;
                if (start) begin
                    if (i_kind == KIND_ALLOC) begin
                        n_ptr = '0;
                    end else begin
                        n_ptr = free_word;
                        n_bit = free_bit;
                        if (!in_range) begin
                            n_valid = 1'b1;
                        end
                    end
                end
            end
            S_SCAN: begin
                ram_raddr = at_last ? r_ptr : r_ptr + WORD_AW'(1);
                if (ffz.found) begin
                    ram_we         = 1'b1;
                    ram_wdata      = ram_rdata | ffz.onehot;
                    n_valid        = 1'b1;
                    n_success      = 1'b1;
                    n_page_address = PAGE_ADDR_W'(grant_full);
                end else if (at_last) begin
                    n_valid = 1'b1;
                end else begin
                    n_ptr = r_ptr + WORD_AW'(1);
                end
            end
            S_FREE: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata & ~(MAP_WORD_BITS'(1) << r_bit);
                n_valid   = 1'b1;
                n_success = 1'b1;
            end
            default: begin
                n_ptr = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ptr   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bit          <= n_bit;
        r_page_address <= n_page_address;
        r_success      <= n_success;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_valid        = r_valid;
    assign o_page_address = r_page_address;
    assign o_success      = r_success;

endmodule

@@ dv/tb_bitmap_page_allocator.sv @@
`timescale 1ns / 1ps

module tb_bitmap_page_allocator
    import bpa_pkg::*;
();

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 3;
    localparam int RANDOM_ITEMS = 580;
    localparam int IDLE_PCT     = 12;
    localparam int QUIET_FIRST  = 200;
    localparam int QUIET_LAST   = 330;
    localparam int FILL_ITEMS   = 250;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int REPORT_MAX   = 10;
    localparam int PLAN_ROWS    = 18;

    localparam logic GRANTED = 1'b1;
    localparam logic REFUSED = 1'b0;

    typedef struct packed {
        logic [PAGE_ADDR_W-1:0] page_address;
        logic                   success;
    } t_grant;

    typedef struct packed {
        logic                   kind;
        logic [ADDR_W-1:0]      addr;
        logic                   typed;
        logic [PAGE_ADDR_W-1:0] page_address;
        logic                   success;
    } t_plan_row;

    logic                   i_clk          = 1'b0;
    logic                   i_rst_n        = 1'b0;
    logic                   start          = 1'b0;
    logic                   i_kind         = KIND_ALLOC;
    logic [ADDR_W-1:0]      i_free_address = '0;
    logic                   busy;
    logic                   o_valid;
    logic [PAGE_ADDR_W-1:0] o_page_address;
    logic                   o_success;

    logic [MAP_WORD_BITS-1:0] page_used [MAP_WORDS];
    t_grant                   pending_grants [$];
    int unsigned              held_pages [$];
    int                       mismatches  = 0;
    int                       cycle_count = 0;
    int                       idle_pct    = IDLE_PCT;

    t_plan_row plan_rows [PLAN_ROWS] = '{
        {KIND_ALLOC, 32'h0000_0000, 1'b1, 27'h000_0000, GRANTED},
        {KIND_ALLOC, 32'h0000_0000, 1'b1, 27'h000_1000, GRANTED},
        {KIND_ALLOC, 32'hFFFF_FFFF, 1'b1, 27'h000_2000, GRANTED},
        {KIND_FREE,  32'h0000_1FFF, 1'b1, 27'h000_0000, GRANTED},
        {KIND_ALLOC, 32'h0000_0000, 1'b0, 27'h000_0000, GRANTED},
        {KIND_FREE,  32'hFFFF_FFFF, 1'b1, 27'h000_0000, REFUSED},
        {KIND_FREE,  32'h0800_0000, 1'b1, 27'h000_0000, REFUSED},
        {KIND_FREE,  32'h07FF_FFFF, 1'b1, 27'h000_0000, GRANTED},
        {KIND_FREE,  32'h0000_0000, 1'b1, 27'h000_0000, GRANTED},
        {KIND_FREE,  32'h0000_0000, 1'b1, 27'h000_0000, GRANTED},
        {KIND_ALLOC, 32'h0000_0000, 1'b0, 27'h000_0000, GRANTED},
        {KIND_FREE,  32'h8000_0FFF, 1'b1, 27'h000_0000, REFUSED},
        {KIND_FREE,  32'h0000_2000, 1'b0, 27'h000_0000, GRANTED},
        {KIND_ALLOC, 32'h0000_0000, 1'b0, 27'h000_0000, GRANTED},
        {KIND_ALLOC, 32'h0000_0000, 1'b0, 27'h000_0000, GRANTED},
        {KIND_FREE,  32'h0555_5555, 1'b0, 27'h000_0000, GRANTED},
        {KIND_FREE,  32'h0AAA_AAAA, 1'b1, 27'h000_0000, REFUSED},
        {KIND_ALLOC, 32'h0000_0000, 1'b0, 27'h000_0000, GRANTED}
    };

    bitmap_page_allocator u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_kind         (i_kind),
        .i_free_address (i_free_address),
        .o_valid        (o_valid),
        .o_page_address (o_page_address),
        .o_success      (o_success)
    );

    always #CLK_HALF i_clk = ~i_clk;

    function automatic t_grant next_grant(input logic kind, input logic [ADDR_W-1:0] addr);
        t_grant answer;
        int     page;
        int     w;
        int     b;
        logic   found;
        answer.page_address = '0;
        answer.success      = REFUSED;
        found               = 1'b0;
        if (kind == KIND_ALLOC) begin
            for (w = 0; w < MAP_WORDS; w++) begin
                if (!found && page_used[w] != '1) begin
                    for (b = 0; b < MAP_WORD_BITS; b++) begin
                        page = w * MAP_WORD_BITS + b;
                        if (!found && page < NUM_PAGES && !page_used[w][b]) begin
                            found               = 1'b1;
                            page_used[w][b]     = 1'b1;
                            answer.page_address = PAGE_ADDR_W'(longint'(page) * PAGE_BYTES);
                            answer.success      = GRANTED;
                        end
                    end
                end
            end
        end else begin
            page = int'(addr / PAGE_BYTES);
            if (page < NUM_PAGES) begin
                page_used[page / MAP_WORD_BITS][page % MAP_WORD_BITS] = 1'b0;
                answer.success = GRANTED;
            end
        end
        return answer;
    endfunction

    // hold start high until the block takes the item, then predict it
    task automatic issue_request(input logic kind, input logic [ADDR_W-1:0] addr,
                                 output t_grant predicted);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        start          <= 1'b1;
        i_kind         <= kind;
        i_free_address <= addr;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predicted = next_grant(kind, addr);
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_grant want;
        if (i_rst_n && o_valid) begin
            if (pending_grants.size() == 0) begin
                if (mismatches < REPORT_MAX)
                    $display("unexpected result: page_address %h success %b",
                             o_page_address, o_success);
                mismatches++;
            end else begin
                want = pending_grants.pop_front();
                if (o_page_address !== want.page_address || o_success !== want.success) begin
                    if (mismatches < REPORT_MAX)
                        $display("mismatch: expected page_address %h success %b, got %h %b",
                                 want.page_address, want.success, o_page_address, o_success);
                    mismatches++;
                end
            end
        end
    end

    initial begin : stimulus
        t_plan_row             row;
        t_grant                predicted;
        t_grant                typed_grant;
        logic                  kind;
        logic [ADDR_W-1:0]     addr;
        int                    alloc_pct;
        int                    sel;
        int                    idx;
        for (int w = 0; w < MAP_WORDS; w++) page_used[w] = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < PLAN_ROWS; r++) begin
            row = plan_rows[r];
            issue_request(row.kind, row.addr, predicted);
            if (row.typed) begin
                typed_grant.page_address = row.page_address;
                typed_grant.success      = row.success;
                pending_grants.push_back(typed_grant);
            end else begin
                pending_grants.push_back(predicted);
            end
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            idle_pct  = (n >= QUIET_FIRST && n < QUIET_LAST) ? 0 : IDLE_PCT;
            alloc_pct = (n < FILL_ITEMS) ? 75 : 50;
            kind      = KIND_FREE;
            addr      = $urandom;
            if ($urandom_range(99) < alloc_pct) begin
                kind = KIND_ALLOC;
            end else begin
                sel = $urandom_range(9);
                if (sel < 6 && held_pages.size() > 0) begin
                    idx  = $urandom_range(held_pages.size() - 1);
                    addr = ADDR_W'(held_pages[idx]) * PAGE_BYTES
                         + ADDR_W'($urandom_range(PAGE_BYTES - 1));
                    held_pages.delete(idx);
                end else if (sel < 8) begin
                    addr = addr & 32'h07FF_FFFF;
                end else if (addr[ADDR_W-1:PAGE_ADDR_W] == '0) begin
                    addr[$urandom_range(ADDR_W - 1, PAGE_ADDR_W)] = 1'b1;
                end
            end
            issue_request(kind, addr, predicted);
            pending_grants.push_back(predicted);
            if (kind == KIND_ALLOC && predicted.success == GRANTED)
                held_pages.push_back(int'(predicted.page_address) / PAGE_BYTES);
        end
        start <= 1'b0;

        while (pending_grants.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/bpa_pkg.sv
rtl/bpa_ram.sv
rtl/bpa_ffz.sv
rtl/bitmap_page_allocator.sv
dv/tb_bitmap_page_allocator.sv
